@@ rtl/circle_outline_rasterizer_defines.svh @@
// assertion macros used by the checker file
`ifndef CIRCLE_OUTLINE_RASTERIZER_DEFINES_SVH
`define CIRCLE_OUTLINE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define CRR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/crr_pkg.sv @@
package crr_pkg;

   localparam int COORD_W  = 10;
   localparam int RADIUS_W = 6;
   localparam int COLOR_W  = 16;
   localparam int SQ_W     = 2 * RADIUS_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RESET = COORD_W'(160);
   localparam logic [COORD_W-1:0] SCREEN_WIDTH_RESET  = COORD_W'(128);

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_HEIGHT = 1'b0;
   localparam logic CSR_IDX_WIDTH  = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [COORD_W-1:0]  center_x;
      logic [COORD_W-1:0]  center_y;
      logic [RADIUS_W-1:0] radius;
      logic [COLOR_W-1:0]  color;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_plus_dx;
      logic [COORD_W-1:0] x_minus_dx;
      logic [COORD_W-1:0] x_plus_dy;
      logic [COORD_W-1:0] x_minus_dy;
      logic [COORD_W-1:0] y_plus_dx;
      logic [COORD_W-1:0] y_minus_dx;
      logic [COORD_W-1:0] y_plus_dy;
      logic [COORD_W-1:0] y_minus_dy;
      logic [COLOR_W-1:0] pixel_color;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

endpackage

@@ rtl/crr_queue.sv @@
module crr_queue
   import crr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  req_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output req_type pop_data
);

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   req_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/crr_front.sv @@
module crr_front
   import crr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output req_type               push_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [COORD_W-1:0] screen_height_ff, screen_height_in;
   logic [COORD_W-1:0] screen_width_ff, screen_width_in;
   logic               csr_write;
   logic [COORD_W:0]   x_hi, y_hi;
   logic               fits;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      screen_height_in = screen_height_ff;
      screen_width_in  = screen_width_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_IDX_HEIGHT: screen_height_in = pwdata[COORD_W-1:0];
            CSR_IDX_WIDTH:  screen_width_in  = pwdata[COORD_W-1:0];
            default:        screen_height_in = screen_height_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_HEIGHT: prdata = CSR_DATA_W'(screen_height_ff);
         CSR_IDX_WIDTH:  prdata = CSR_DATA_W'(screen_width_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
      end else begin
         screen_height_ff <= screen_height_in;
         screen_width_ff  <= screen_width_in;
      end
   end

   // whole circle must lie on screen, otherwise the command is dropped
   assign x_hi = (COORD_W+1)'(req_data.center_x) + (COORD_W+1)'(req_data.radius);
   assign y_hi = (COORD_W+1)'(req_data.center_y) + (COORD_W+1)'(req_data.radius);
   assign fits = (req_data.center_x >= COORD_W'(req_data.radius))
               & (x_hi <= (COORD_W+1)'(screen_height_ff))
               & (req_data.center_y >= COORD_W'(req_data.radius))
               & (y_hi <= (COORD_W+1)'(screen_width_ff));

   assign req_ready  = push_ready;
   assign push_valid = req_valid & fits;
   assign push_data  = req_data;

endmodule

@@ rtl/crr_back.sv @@
module crr_back
   import crr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  req_type  pop_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   back_state_type      state_ff, state_in;
   req_type             cmd_ff, cmd_in;
   logic [RADIUS_W-1:0] dx_ff, dx_in;
   logic [RADIUS_W-1:0] dy_ff, dy_in;
   logic [SQ_W-1:0]     dx2_ff, dx2_in;
   logic [SQ_W-1:0]     dy2_ff, dy2_in;
   logic [SQ_W-1:0]     rr_ff, rr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [SQ_W-1:0]     radius_sq;
   logic [SQ_W:0]       dist_sq;
   logic                out_free;
   logic                out_load;

   assign radius_sq = SQ_W'(pop_data.radius) * SQ_W'(pop_data.radius);
   assign dist_sq   = (SQ_W+1)'(dx2_ff) + (SQ_W+1)'(dy2_ff);
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dx2_in    = dx2_ff;
      dy2_in    = dy2_ff;
      rr_in     = rr_ff;
      pop_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in   = pop_data;
               dx_in    = '0;
               dy_in    = pop_data.radius;
               dx2_in   = '0;
               dy2_in   = radius_sq;
               rr_in    = radius_sq + SQ_W'(1);
               state_in = BK_RUN;
            end
         end
         BK_RUN: begin
            // step dy down while dx^2 + dy^2 > r^2 + 1
            if ((dy_ff != '0) && (dist_sq > (SQ_W+1)'(rr_ff))) begin
               dy_in  = dy_ff - 1'b1;
               dy2_in = dy2_ff - (SQ_W'({dy_ff, 1'b0}) - SQ_W'(1));
            end else if (out_free) begin
               out_load = 1'b1;
               if (dx_ff == cmd_ff.radius) begin
                  state_in = BK_IDLE;
               end else begin
                  dx_in  = dx_ff + 1'b1;
                  dx2_in = dx2_ff + SQ_W'({dx_ff, 1'b0}) + SQ_W'(1);
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in.x_plus_dx   = cmd_ff.center_x + COORD_W'(dx_ff);
      rsp_data_in.x_minus_dx  = cmd_ff.center_x - COORD_W'(dx_ff);
      rsp_data_in.x_plus_dy   = cmd_ff.center_x + COORD_W'(dy_ff);
      rsp_data_in.x_minus_dy  = cmd_ff.center_x - COORD_W'(dy_ff);
      rsp_data_in.y_plus_dx   = cmd_ff.center_y + COORD_W'(dx_ff);
      rsp_data_in.y_minus_dx  = cmd_ff.center_y - COORD_W'(dx_ff);
      rsp_data_in.y_plus_dy   = cmd_ff.center_y + COORD_W'(dy_ff);
      rsp_data_in.y_minus_dy  = cmd_ff.center_y - COORD_W'(dy_ff);
      rsp_data_in.pixel_color = cmd_ff.color;
      rsp_data_in.last        = (dx_ff == cmd_ff.radius);
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      dx2_ff <= dx2_in;
      dy2_ff <= dy2_in;
      rr_ff  <= rr_in;
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/circle_outline_rasterizer.sv @@
// Circle outline rasterizer. A command on req_ (centre, radius, colour) is checked at the
// front against screen_height (centre x) and screen_width (centre y); a circle that does
// not fit wholly on screen is taken while the queue has room and gives no result. A
// circle that fits waits in a two-command queue and then gives radius+1 results on rsp_,
// one per dx from 0 to radius, each with the eight symmetric pixel coordinates and last
// set on dx equal to radius. The back end's stepping loop sets the rate: it loads a
// command, then in each step either decrements dy or, while the output is free, gives
// a result; dy ends at one for a nonzero radius and at zero for radius zero. Results are
// held off while the receiver stalls, and the front keeps taking commands until the
// queue is full.
module circle_outline_rasterizer
   import crr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;
   req_type  push_data, pop_data;

   crr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   crr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   crr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/crr_checker.sv @@
`include "circle_outline_rasterizer_defines.svh"

module crr_checker
   import crr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   `CRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // x and y pairs share the same dx
   `CRR_ASSERT_NOW(a_dx_pair, clock, reset, rsp_valid, COORD_W'(rsp_data.x_plus_dx - rsp_data.x_minus_dx) == COORD_W'(rsp_data.y_plus_dx - rsp_data.y_minus_dx))

   // x and y pairs share the same dy
   `CRR_ASSERT_NOW(a_dy_pair, clock, reset, rsp_valid, COORD_W'(rsp_data.x_plus_dy - rsp_data.x_minus_dy) == COORD_W'(rsp_data.y_plus_dy - rsp_data.y_minus_dy))

   // within one circle the colour holds and dx steps by one
   `CRR_ASSERT_NEXT(a_same_circle, clock, reset, rsp_valid && rsp_ready && !rsp_data.last, !rsp_valid || ((rsp_data.pixel_color == $past(rsp_data.pixel_color)) && (rsp_data.x_plus_dx == COORD_W'($past(rsp_data.x_plus_dx) + COORD_W'(1)))))

endmodule

bind circle_outline_rasterizer crr_checker u_crr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/tb_circle_outline_rasterizer.sv @@
`timescale 1ns / 1ps

module tb_circle_outline_rasterizer;
   import crr_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   localparam int MAX_RADIUS = 63;

   circle_outline_rasterizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #1 clock = ~clock;

   // shadow of the screen registers
   int      screen_h = int'(SCREEN_HEIGHT_RESET);
   int      screen_w = int'(SCREEN_WIDTH_RESET);

   req_type pending_circles[$];
   rsp_type outline_rows[$];
   int      errors = 0;
   bit      idle_on = 1'b1;
   bit      req_took = 1'b0;
   int      req_gap = 0;
   int      rsp_stall = 0;
   int      rsp_hold_req = 0;
   int      rsp_hold_left = 0;

   // expected outline rows of one circle command
   task automatic expand_circle(input req_type c);
      int      cx, cy, r, dy, lim, rr;
      rsp_type row;
      cx = int'(c.center_x);
      cy = int'(c.center_y);
      r  = int'(c.radius);
      if (r > MAX_RADIUS) return;
      if (cx < r || cx + r > screen_h || cy < r || cy + r > screen_w) return;
      rr = r * r + 1;
      dy = r;
      for (int dx = 0; dx <= r; dx++) begin
         lim = rr - dx * dx;
         while (dy > 0 && dy * dy > lim) dy--;
         row.x_plus_dx   = COORD_W'(cx + dx);
         row.x_minus_dx  = COORD_W'(cx - dx);
         row.x_plus_dy   = COORD_W'(cx + dy);
         row.x_minus_dy  = COORD_W'(cx - dy);
         row.y_plus_dx   = COORD_W'(cy + dx);
         row.y_minus_dx  = COORD_W'(cy - dx);
         row.y_plus_dy   = COORD_W'(cy + dy);
         row.y_minus_dy  = COORD_W'(cy - dy);
         row.pixel_color = c.color;
         row.last        = (dx == r);
         outline_rows.push_back(row);
      end
   endtask

   // input transfer: predict at acceptance
   always @(posedge clock) begin
      req_took = !reset && req_valid && req_ready;
      if (req_took) expand_circle(req_data);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_circles.size() > 0) begin
            req_data  <= pending_circles.pop_front();
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 19);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 15) == 0) rsp_stall = $urandom_range(1, 19);
      end
   end

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
         errors++;
      end
   endtask

   // result transfer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outline_rows.size() == 0) begin
            $display("%0t: unexpected result expected none got %h", $realtime, rsp_data);
            errors++;
         end else begin
            want = outline_rows.pop_front();
            check_field("x_plus_dx", want.x_plus_dx, rsp_data.x_plus_dx);
            check_field("x_minus_dx", want.x_minus_dx, rsp_data.x_minus_dx);
            check_field("x_plus_dy", want.x_plus_dy, rsp_data.x_plus_dy);
            check_field("x_minus_dy", want.x_minus_dy, rsp_data.x_minus_dy);
            check_field("y_plus_dx", want.y_plus_dx, rsp_data.y_plus_dx);
            check_field("y_minus_dx", want.y_minus_dx, rsp_data.y_minus_dx);
            check_field("y_plus_dy", want.y_plus_dy, rsp_data.y_plus_dy);
            check_field("y_minus_dy", want.y_minus_dy, rsp_data.y_minus_dy);
            check_field("pixel_color", want.pixel_color, rsp_data.pixel_color);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   task automatic write_screen(input logic idx, input int unsigned val);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_W'({idx, 2'b00});
      pwdata  = ($urandom() & ~32'h3ff) | (val & 32'h3ff);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      if (idx == CSR_IDX_HEIGHT) screen_h = val & 32'h3ff;
      else screen_w = val & 32'h3ff;
   endtask

   task automatic send_circle(input int cx, input int cy, input int r, input int col);
      req_type c;
      c.center_x = COORD_W'(cx);
      c.center_y = COORD_W'(cy);
      c.radius   = RADIUS_W'(r);
      c.color    = COLOR_W'(col);
      pending_circles.push_back(c);
   endtask

   // mostly circles that fit, with small radii; the rest random noise
   task automatic send_random(input int count);
      int rmax, r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_circle($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 63), $urandom_range(0, 65535));
         end else begin
            rmax = MAX_RADIUS;
            if (screen_h / 2 < rmax) rmax = screen_h / 2;
            if (screen_w / 2 < rmax) rmax = screen_w / 2;
            if ($urandom_range(0, 9) == 0) r = $urandom_range(0, rmax);
            else r = $urandom_range(0, (rmax < 12) ? rmax : 12);
            send_circle($urandom_range(r, screen_h - r), $urandom_range(r, screen_w - r),
                        r, $urandom_range(0, 65535));
         end
      end
   endtask

   task automatic drain;
      while (pending_circles.size() != 0 || req_valid) @(posedge clock);
      while (outline_rows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset screen 160 x 128
      send_circle(0, 0, 0, 0);
      send_circle(160, 128, 0, 'hffff);
      send_circle(97, 65, 63, 'h5a5a);
      send_circle(10, 10, 10, 'ha5a5);
      send_circle(150, 118, 10, 'h1234);
      send_circle(5, 50, 6, 'h0f0f);
      send_circle(156, 50, 5, 'hf0f0);
      send_circle(50, 3, 4, 'h00ff);
      send_circle(50, 125, 4, 'hff00);
      send_circle(161, 64, 0, 'h7777);
      send_circle(80, 129, 0, 'h8888);
      send_circle(1023, 1023, 63, 'hffff);
      send_circle(40, 40, 1, 'h0001);
      send_circle(40, 40, 2, 'h8000);
      send_random(70);
      drain();

      write_screen(CSR_IDX_HEIGHT, 1023);
      write_screen(CSR_IDX_WIDTH, 1023);
      send_circle(1023, 1023, 0, 'h3c3c);
      send_circle(960, 960, 63, 'hc3c3);
      send_circle(63, 63, 63, 'h0ff0);
      send_circle(1000, 500, 31, 'hbeef);
      send_random(80);
      drain();

      // zero screen on one axis
      write_screen(CSR_IDX_HEIGHT, 0);
      send_circle(0, 500, 0, 'h1111);
      send_circle(0, 500, 1, 'h2222);
      send_circle(1, 500, 0, 'h3333);
      send_random(8);
      drain();
      write_screen(CSR_IDX_HEIGHT, 1023);
      write_screen(CSR_IDX_WIDTH, 0);
      send_circle(500, 0, 0, 'h4444);
      send_circle(500, 1, 0, 'h5555);
      send_random(8);
      drain();

      write_screen(CSR_IDX_HEIGHT, 1);
      write_screen(CSR_IDX_WIDTH, 1);
      send_circle(1, 1, 0, 'h6666);
      send_circle(0, 1, 1, 'h9999);
      send_random(8);
      drain();

      // long receiver hold while commands keep coming
      write_screen(CSR_IDX_HEIGHT, 200);
      write_screen(CSR_IDX_WIDTH, 300);
      @(posedge clock);
      rsp_hold_req = 400;
      send_random(80);
      drain();

      write_screen(CSR_IDX_HEIGHT, 160);
      write_screen(CSR_IDX_WIDTH, 128);
      idle_on = 1'b0;
      send_random(70);
      drain();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("FAILURE");
      $finish;
   end

endmodule
